// ----- rtl/dqz_pkg.sv -----
// Shared types, cosine and scan tables for the 8x8 DCT quantizer.
package dqz_pkg;

	localparam int DEF_COEF_FRAC_BITS = 14;
	localparam int QUANT_QW           = 20;
	localparam logic [15:0] QS_RESET  = 16'd256;

	typedef int int_row_t [8];
	typedef logic [5:0] idx_tab_t [64];

	typedef struct packed {
		logic       v;
		logic [2:0] k;
	} dqz_link_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_P1,
		ST_P2,
		ST_QSTART,
		ST_QWAIT,
		ST_ORD,
		ST_OLD,
		ST_OSEND
	} dqz_state_t;

	typedef enum logic [1:0] {
		QS_IDLE,
		QS_PREP,
		QS_RUN,
		QS_FIN
	} dqz_qstate_t;

	localparam int COS_MAG [8][8] = '{
		'{3536, 3536, 3536, 3536, 3536, 3536, 3536, 3536},
		'{4904, 4157, 2778, 975, -975, -2778, -4157, -4904},
		'{4619, 1913, -1913, -4619, -4619, -1913, 1913, 4619},
		'{4157, -975, -4904, -2778, 2778, 4904, 975, -4157},
		'{3536, -3536, -3536, 3536, 3536, -3536, -3536, 3536},
		'{2778, -4904, 975, 4157, -4157, -975, 4904, -2778},
		'{1913, -4619, 4619, -1913, -1913, 4619, -4619, 1913},
		'{975, -2778, 4157, -4904, 4904, -4157, 2778, -975}
	};

	localparam idx_tab_t SCAN_POS = '{
		 0,  8,  1,  2,  9, 16, 24, 17,
		10,  3,  4, 11, 18, 25, 32, 40,
		33, 26, 19, 12,  5,  6, 13, 20,
		27, 34, 41, 48, 56, 49, 42, 35,
		28, 21, 14,  7, 15, 22, 29, 36,
		43, 50, 57, 58, 51, 44, 37, 30,
		23, 31, 38, 45, 52, 59, 60, 53,
		46, 39, 47, 54, 61, 62, 55, 63
	};

	function automatic int_row_t cos_row(int m, int f);
		int_row_t r;
		int v;
		int a;
		int c;
		for (int k = 0; k < 8; k++) begin
			v = COS_MAG[m][k];
			a = (v < 0) ? -v : v;
			c = (a * (1 << f) + 5000) / 10000;
			r[k] = (v < 0) ? -c : c;
		end
		return r;
	endfunction

	function automatic idx_tab_t scan_inverse();
		idx_tab_t t;
		for (int i = 0; i < 64; i++) begin
			t[SCAN_POS[i]] = 6'(i);
		end
		return t;
	endfunction

	localparam idx_tab_t SCAN_IDX = scan_inverse();

endpackage

// ----- rtl/dct8x8_quantize_zigzag.sv -----
// 8x8 DCT with quantization and zigzag readout, top level.
// Takes one pixel per cycle while loading; 64 pixels form a block.
// After the 64th pixel: a column pass, then for each of 8 rows a row pass and 8 quantizer
// runs, then each result is fetched from the quant RAM and offered in zigzag order.
// No new pixels are taken until the last result of a block has transferred.
// Async reset clears control state and sets quant_scale to 256.
module dct8x8_quantize_zigzag import dqz_pkg::*; #(
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               quant_scale_wr_en,
	input  logic [15:0]        quant_scale_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         pixel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [12:0] coefficient,
	output logic [5:0]         scan_index,
	output logic               last_of_block
);

	localparam int F  = COEF_FRAC_BITS;
	localparam int XW = F + 11;
	localparam int AW = 2 * F + 13;

	dqz_state_t st_q, st_d;

	logic [15:0] qs_q;
	logic [5:0]  cnt_q;
	logic [2:0]  vec_q;
	logic [4:0]  sc_q;
	logic [2:0]  m_q;
	logic [5:0]  last_q;
	logic [5:0]  s_q;
	logic        feed_v_q;
	logic [2:0]  feed_k_q;

	logic [4:0]  sc_m;
	logic [2:0]  drain_m;
	logic        feed;
	logic        in_xfer;
	logic        out_xfer;

	logic [7:0]            pix_rdata;
	logic [XW-1:0]         t_rdata;
	logic [12:0]           q_rdata;
	logic                  t_we;
	logic [5:0]            t_waddr;
	logic [5:0]            q_waddr;
	logic                  q_done;
	logic signed [12:0]    q_z;

	dqz_link_t              link_c [8];
	logic signed [XW-1:0]   x_c [8];
	logic signed [AW-1:0]   res_c [8];
	dqz_link_t              link_h;
	logic signed [XW-1:0]   x_h;

	assign in_ready  = (st_q == ST_LOAD);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = (st_q == ST_OSEND);
	assign out_xfer  = out_valid && out_ready;
	assign feed      = ((st_q == ST_P1) || (st_q == ST_P2)) && (sc_q < 5'd8);
	assign sc_m      = sc_q - 5'd17;
	assign drain_m   = sc_m[2:0];
	assign t_we      = (st_q == ST_P1) && (sc_q >= 5'd17);
	assign t_waddr   = {drain_m, vec_q};
	assign q_waddr   = {vec_q, m_q};

	dqz_ram #(.W(8), .D(64)) u_pix_ram (
		.clk   (clk),
		.we    (in_xfer),
		.waddr (cnt_q),
		.wdata (pixel),
		.raddr ({sc_q[2:0], vec_q}),
		.rdata (pix_rdata)
	);

	dqz_ram #(.W(XW), .D(64)) u_t_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (XW'(res_c[drain_m])),
		.raddr ({vec_q, sc_q[2:0]}),
		.rdata (t_rdata)
	);

	dqz_ram #(.W(13), .D(64)) u_q_ram (
		.clk   (clk),
		.we    ((st_q == ST_QWAIT) && q_done),
		.waddr (q_waddr),
		.wdata (q_z),
		.raddr (SCAN_POS[s_q]),
		.rdata (q_rdata)
	);

	assign link_h.v = feed_v_q;
	assign link_h.k = feed_k_q;
	assign x_h = (st_q == ST_P2) ? $signed(t_rdata) : $signed({{(XW-8){1'b0}}, pix_rdata});

	for (genvar g = 0; g < 8; g++) begin : g_cell
		dqz_cell #(.F(F), .M(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.link_i ((g == 0) ? link_h : link_c[(g == 0) ? 0 : g-1]),
			.x_i    ((g == 0) ? x_h : x_c[(g == 0) ? 0 : g-1]),
			.link_o (link_c[g]),
			.x_o    (x_c[g]),
			.res_o  (res_c[g])
		);
	end

	dqz_quant #(.F(F)) u_quant (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (st_q == ST_QSTART),
		.y      (res_c[m_q]),
		.d      (4'(vec_q) + 4'(m_q) + 4'd1),
		.qs     (qs_q),
		.done   (q_done),
		.z      (q_z)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_LOAD:   if (in_xfer && cnt_q == 6'd63) st_d = ST_P1;
			ST_P1:     if (sc_q == 5'd24 && vec_q == 3'd7) st_d = ST_P2;
			ST_P2:     if (sc_q == 5'd17) st_d = ST_QSTART;
			ST_QSTART: st_d = ST_QWAIT;
			ST_QWAIT: begin
				if (q_done) begin
					if (m_q != 3'd7) st_d = ST_QSTART;
					else if (vec_q != 3'd7) st_d = ST_P2;
					else st_d = ST_ORD;
				end
			end
			ST_ORD:    st_d = ST_OLD;
			ST_OLD:    st_d = ST_OSEND;
			ST_OSEND:  if (out_xfer) st_d = (s_q == last_q) ? ST_LOAD : ST_ORD;
			default:   st_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_LOAD;
			qs_q     <= QS_RESET;
			cnt_q    <= '0;
			vec_q    <= '0;
			sc_q     <= '0;
			m_q      <= '0;
			last_q   <= '0;
			s_q      <= '0;
			feed_v_q <= 1'b0;
			feed_k_q <= '0;
		end else begin
			st_q     <= st_d;
			feed_v_q <= feed;
			feed_k_q <= sc_q[2:0];
			if (quant_scale_wr_en) qs_q <= quant_scale_wr_data;
			case (st_q)
				ST_LOAD: begin
					if (in_xfer) cnt_q <= cnt_q + 1'b1;
					vec_q  <= '0;
					sc_q   <= '0;
					last_q <= '0;
				end
				ST_P1: begin
					if (sc_q == 5'd24) begin
						sc_q  <= '0;
						vec_q <= vec_q + 1'b1;
					end else begin
						sc_q <= sc_q + 1'b1;
					end
				end
				ST_P2: begin
					sc_q <= sc_q + 1'b1;
					m_q  <= '0;
				end
				ST_QWAIT: begin
					if (q_done) begin
						if (q_z != 13'sd0 && SCAN_IDX[q_waddr] > last_q) begin
							last_q <= SCAN_IDX[q_waddr];
						end
						m_q  <= m_q + 1'b1;
						sc_q <= '0;
						s_q  <= '0;
						if (m_q == 3'd7) vec_q <= vec_q + 1'b1;
					end
				end
				ST_OSEND: if (out_xfer) s_q <= s_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OLD) begin
			coefficient   <= q_rdata;
			scan_index    <= s_q;
			last_of_block <= (s_q == last_q);
		end
	end

endmodule

// ----- rtl/dqz_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dqz_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/dqz_cell.sv -----
// One multiply-accumulate cell of the transform chain.
module dqz_cell import dqz_pkg::*; #(
	parameter int F = DEF_COEF_FRAC_BITS,
	parameter int M = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dqz_link_t               link_i,
	input  logic signed [F+10:0]    x_i,
	output dqz_link_t               link_o,
	output logic signed [F+10:0]    x_o,
	output logic signed [2*F+12:0]  res_o
);

	localparam int XW = F + 11;
	localparam int CW = F;
	localparam int PW = XW + CW;
	localparam int AW = 2 * F + 13;
	localparam int_row_t COEF = cos_row(M, F);

	logic signed [CW-1:0] coef;
	logic signed [PW-1:0] prod_s1;
	logic                 v_s1;
	logic [2:0]           k_s1;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] acc_d;

	assign coef = CW'(COEF[link_i.k]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_o <= '0;
			v_s1   <= 1'b0;
			k_s1   <= '0;
		end else begin
			link_o <= link_i;
			v_s1   <= link_i.v;
			k_s1   <= link_i.k;
		end
	end

	always_ff @(posedge clk) begin
		x_o     <= x_i;
		prod_s1 <= x_i * coef;
	end

	assign acc_d = (k_s1 == 3'd0) ? AW'(prod_s1) : acc_q + AW'(prod_s1);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			acc_q <= acc_d;
			if (k_s1 == 3'd7) begin
				res_o <= acc_d;
			end
		end
	end

endmodule

// ----- rtl/dqz_quant.sv -----
// Quantizer: scaled rounding division, one quotient bit per cycle, with saturation.
module dqz_quant import dqz_pkg::*; #(
	parameter int F = DEF_COEF_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [2*F+12:0] y,
	input  logic [3:0]             d,
	input  logic [15:0]            qs,
	output logic                   done,
	output logic signed [12:0]     z
);

	localparam int AW = 2 * F + 13;
	localparam int QW = QUANT_QW;
	localparam int DW = 20;
	localparam int SW = 2 * F + 16;
	localparam int SA = 2 * F - 5;
	localparam int SH = 2 * F - 4;
	localparam int CNW = $clog2(QW);

	dqz_qstate_t st_q, st_d;

	logic            neg_q;
	logic [AW-1:0]   mag_q;
	logic [DW-1:0]   den_q;
	logic [QW-1:0]   dv_q;
	logic [DW-1:0]   rem_q;
	logic [CNW-1:0]  cnt_q;
	logic [15:0]     qs_eff;
	logic [SW-1:0]   sum;
	logic [DW:0]     tr;
	logic            ge;

	assign qs_eff = (qs == 16'd0) ? 16'd1 : qs;
	assign sum    = SW'({mag_q, 1'b0}) + (SW'(den_q) << SA);
	assign tr     = {rem_q, dv_q[QW-1]};
	assign ge     = (tr >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= QS_IDLE;
			done <= 1'b0;
		end else begin
			st_q <= st_d;
			done <= (st_q == QS_FIN);
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			QS_IDLE: if (start) st_d = QS_PREP;
			QS_PREP: st_d = QS_RUN;
			QS_RUN:  if (cnt_q == CNW'(QW - 1)) st_d = QS_FIN;
			QS_FIN:  st_d = QS_IDLE;
			default: st_d = QS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			QS_IDLE: begin
				neg_q <= y[AW-1];
				mag_q <= y[AW-1] ? AW'(-y) : AW'(y);
				den_q <= DW'(d) * DW'(qs_eff);
			end
			QS_PREP: begin
				dv_q  <= QW'(sum >> SH);
				rem_q <= '0;
				cnt_q <= '0;
			end
			QS_RUN: begin
				rem_q <= ge ? DW'(tr - {1'b0, den_q}) : DW'(tr);
				dv_q  <= {dv_q[QW-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			QS_FIN: begin
				if (!neg_q) begin
					z <= (dv_q > QW'(4095)) ? 13'sd4095 : 13'(dv_q);
				end else begin
					z <= (dv_q > QW'(4096)) ? -13'sd4096 : 13'(-$signed({1'b0, dv_q}));
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- dv/dct8x8_quantize_zigzag_test.sv -----
// Testbench for the 8x8 DCT quantizer with zigzag readout: directed and random blocks.
module dct8x8_quantize_zigzag_test;
	import dqz_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [12:0] coef;
		logic [5:0]         idx;
		logic               last;
	} coef_item_t;

	localparam int FB = DEF_COEF_FRAC_BITS;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 0;
	logic arst_n = 0;
	logic quant_scale_wr_en = 0;
	logic [15:0] quant_scale_wr_data = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [7:0] pixel = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [12:0] coefficient;
	logic [5:0] scan_index;
	logic last_of_block;

	dct8x8_quantize_zigzag DUT (
		.clk(clk), .arst_n(arst_n),
		.quant_scale_wr_en(quant_scale_wr_en), .quant_scale_wr_data(quant_scale_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
		.out_valid(out_valid), .out_ready(out_ready),
		.coefficient(coefficient), .scan_index(scan_index), .last_of_block(last_of_block)
	);

	// predictor state
	logic [15:0] qscale = QS_RESET;
	logic [7:0]  pix_buf [64];
	int          pix_count = 0;
	longint      ctab [8][8];
	coef_item_t  expected_coefs [$];
	int          errors = 0;
	int          blocks_sent = 0;
	int          coefs_seen = 0;
	bit          hold_off = 0;
	longint      cycles = 0;

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic report(string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	function automatic logic signed [12:0] quantize_coef(longint y, int r, int c);
		longint unsigned qs, den, mag, q;
		longint num;
		bit neg;
		qs = (qscale == 0) ? 1 : qscale;
		den = (longint'(1) << (2 * FB)) * (8 + 8 * (r + c)) * qs;
		num = y * 256;
		neg = num < 0;
		mag = neg ? -num : num;
		q = (2 * mag + den) / (2 * den);
		if (!neg && q > 4095) return 13'sd4095;
		if (neg && q > 4096) return -13'sd4096;
		return neg ? -13'(q) : 13'(q);
	endfunction

	task automatic predict_block();
		longint t [64];
		longint s;
		logic signed [12:0] zq [64];
		int last;
		coef_item_t e;
		last = 0;
		for (int i = 0; i < 8; i++)
			for (int j = 0; j < 8; j++) begin
				s = 0;
				for (int k = 0; k < 8; k++) s += ctab[i][k] * pix_buf[k * 8 + j];
				t[i * 8 + j] = s;
			end
		for (int i = 0; i < 8; i++)
			for (int j = 0; j < 8; j++) begin
				s = 0;
				for (int k = 0; k < 8; k++) s += t[i * 8 + k] * ctab[j][k];
				zq[i * 8 + j] = quantize_coef(s, i, j);
			end
		for (int i = 0; i < 64; i++)
			if (zq[SCAN_POS[i]] != 0) last = i;
		for (int i = 0; i <= last; i++) begin
			e.coef = zq[SCAN_POS[i]];
			e.idx = 6'(i);
			e.last = (i == last);
			expected_coefs.push_back(e);
		end
		blocks_sent++;
	endtask

	task automatic idle_gap(int longest);
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, longest) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(negedge clk);
		end
	endtask

	// valid stays up into the next pixel unless a gap or a drain drops it
	task automatic send_pixel(logic [7:0] p, bit gaps);
		if (gaps) idle_gap(40);
		in_valid <= 1;
		pixel <= p;
		do @(posedge clk); while (!in_ready);
		pix_buf[pix_count] = p;
		pix_count++;
		if (pix_count == 64) begin
			pix_count = 0;
			predict_block();
		end
		@(negedge clk);
	endtask

	// sink
	initial begin
		coef_item_t e;
		forever begin
			@(negedge clk);
			out_ready <= !hold_off && ($urandom_range(0, 9) != 0 ||
				$urandom_range(0, 1) == 0);
			@(posedge clk);
			if (out_valid && out_ready) begin
				coefs_seen++;
				if (expected_coefs.size() == 0) report("coefficient with none expected");
				else begin
					e = expected_coefs.pop_front();
					if (coefficient !== e.coef)
						report($sformatf("idx %0d coef %0d want %0d", e.idx, coefficient, e.coef));
					if (scan_index !== e.idx)
						report($sformatf("scan_index %0d want %0d", scan_index, e.idx));
					if (last_of_block !== e.last)
						report($sformatf("idx %0d last %0b want %0b", e.idx, last_of_block, e.last));
				end
			end
		end
	end

	task automatic drain();
		in_valid <= 0;
		while (expected_coefs.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_scale(logic [15:0] v);
		quant_scale_wr_en <= 1;
		quant_scale_wr_data <= v;
		@(negedge clk);
		quant_scale_wr_en <= 0;
		qscale = v;
	endtask

	task automatic send_block(int kind, bit gaps);
		for (int i = 0; i < 64; i++)
			case (kind)
				0: send_pixel(8'd0, gaps);
				1: send_pixel(8'd255, gaps);
				2: send_pixel(((i / 8 + i % 8) % 2) ? 8'd255 : 8'd0, gaps);
				3: send_pixel(8'(i * 4), gaps);
				default: send_pixel(8'($urandom), gaps);
			endcase
	endtask

	task automatic test_extremes();
		send_block(0, 0);
		send_block(1, 1);
		drain();
	endtask

	task automatic test_scales();
		logic [15:0] scales [3] = '{16'd0, 16'd15, 16'd65535};
		int kinds [3] = '{2, 1, 4};
		foreach (scales[s]) begin
			write_scale(scales[s]);
			send_block(kinds[s], 1);
			drain();
		end
		write_scale(QS_RESET);
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_off = 1;
				repeat (6000) @(negedge clk);
				hold_off = 0;
			end
			begin
				send_block(4, 0);
				send_block(4, 0);
			end
		join
		drain();
	endtask

	initial begin
		for (int m = 0; m < 8; m++)
			for (int k = 0; k < 8; k++)
				ctab[m][k] = (COS_MAG[m][k] < 0)
					? -((longint'(-COS_MAG[m][k]) * (1 << FB) + 5000) / 10000)
					: ((longint'(COS_MAG[m][k]) * (1 << FB) + 5000) / 10000);
		repeat (8) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		test_extremes();
		test_scales();
		test_backpressure();
		$display("covered %0d blocks, %0d coefficients: zero, flat, checkerboard and random",
			blocks_sent, coefs_seen);
		$display("scales 0, 15, 65535 and 256; one long output stall");
		if (errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/dqz_pkg.sv
rtl/dqz_ram.sv
rtl/dqz_cell.sv
rtl/dqz_quant.sv
rtl/dct8x8_quantize_zigzag.sv
dv/dct8x8_quantize_zigzag_test.sv
